// ===== hw/rtl/sdie_pkg.sv =====
`timescale 1ns / 1ps

package sdie_pkg;

   localparam int MASK_W       = 8;
   localparam int TIME_W       = 32;
   localparam int AMP_W        = 8;
   localparam int AMP10_W      = 12;
   localparam int CH_IDX_W     = 3;
   localparam int CHANNELS_DEF = 8;

   localparam logic KIND_TIME = 1'b0;
   localparam logic KIND_AMP  = 1'b1;

   // one decoded sample waiting to be emitted
   typedef struct packed {
      logic                time_pend;
      logic [TIME_W-1:0]   delta;
      logic [MASK_W-1:0]   changed;
      logic [MASK_W-1:0]   mask;
      logic [AMP10_W-1:0]  amp10;
   } work_type;

endpackage

// ===== hw/rtl/sdie_req_if.sv =====
`timescale 1ns / 1ps

interface sdie_req_if;
   logic                         valid;
   logic                         ready;
   logic [sdie_pkg::TIME_W-1:0]  sample_time_ms;
   logic [sdie_pkg::MASK_W-1:0]  channel_mask;
   logic [sdie_pkg::AMP_W-1:0]   amplitude_pct;
   logic                         first_sample;

   modport source (output valid, sample_time_ms, channel_mask, amplitude_pct, first_sample,
                   input ready);
   modport sink   (input valid, sample_time_ms, channel_mask, amplitude_pct, first_sample,
                   output ready);
endinterface

// ===== hw/rtl/sdie_rsp_if.sv =====
`timescale 1ns / 1ps

interface sdie_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           instr_kind;
   logic [sdie_pkg::CH_IDX_W-1:0]  channel_index;
   logic [sdie_pkg::TIME_W-1:0]    instr_value;
   logic                           last_of_sample;

   modport source (output valid, instr_kind, channel_index, instr_value, last_of_sample,
                   input ready);
   modport sink   (input valid, instr_kind, channel_index, instr_value, last_of_sample,
                   output ready);
endinterface

// ===== hw/rtl/sdie_delta.sv =====
`timescale 1ns / 1ps

module sdie_delta #(
   parameter int CHANNELS = sdie_pkg::CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [sdie_pkg::TIME_W-1:0]  sample_time_ms,
   input  logic [sdie_pkg::MASK_W-1:0]  channel_mask,
   input  logic [sdie_pkg::AMP_W-1:0]   amplitude_pct,
   input  logic                         first_sample,
   output sdie_pkg::work_type           work
);

   // channels at or above CHANNELS never change
   localparam logic [sdie_pkg::MASK_W-1:0] LANE_MASK =
      (CHANNELS >= sdie_pkg::MASK_W) ? {sdie_pkg::MASK_W{1'b1}}
                                     : sdie_pkg::MASK_W'((1 << CHANNELS) - 1);

   logic [sdie_pkg::TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [sdie_pkg::MASK_W-1:0] prev_mask_ff, prev_mask_in;
   logic [sdie_pkg::TIME_W-1:0] base_time;
   logic [sdie_pkg::MASK_W-1:0] base_mask;

   always_comb begin
      base_time = first_sample ? '0 : prev_time_ff;
      base_mask = first_sample ? '0 : prev_mask_ff;

      work.delta     = sample_time_ms - base_time;
      work.time_pend = (work.delta != '0);
      work.changed   = (base_mask ^ channel_mask) & LANE_MASK;
      work.mask      = channel_mask;
      // times ten as shift-and-add
      work.amp10     = {1'b0, amplitude_pct, 3'b000} + {3'b000, amplitude_pct, 1'b0};

      prev_time_in = accept ? sample_time_ms : prev_time_ff;
      prev_mask_in = accept ? channel_mask : prev_mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         prev_mask_ff <= '0;
      end else begin
         prev_time_ff <= prev_time_in;
         prev_mask_ff <= prev_mask_in;
      end
   end

endmodule

// ===== hw/rtl/sdie_emit.sv =====
`timescale 1ns / 1ps

module sdie_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sdie_pkg::work_type  work_new,
   output logic                take,
   sdie_rsp_if.source          rsp_ch
);

   sdie_pkg::work_type work_ff, work_in;

   logic                             out_valid_ff, out_valid_in;
   logic                             out_kind_ff, out_kind_in;
   logic [sdie_pkg::CH_IDX_W-1:0]    out_ch_ff, out_ch_in;
   logic [sdie_pkg::TIME_W-1:0]      out_value_ff, out_value_in;
   logic                             out_last_ff, out_last_in;

   logic                             busy;
   logic                             fire;
   logic                             last;
   logic [sdie_pkg::MASK_W-1:0]      low_bit;
   logic [sdie_pkg::MASK_W-1:0]      rest;
   logic [sdie_pkg::CH_IDX_W-1:0]    idx;
   sdie_pkg::work_type               work_step;

   always_comb begin
      busy    = work_ff.time_pend | (|work_ff.changed);
      fire    = busy & (~out_valid_ff | rsp_ch.ready);
      low_bit = work_ff.changed & (~work_ff.changed + 1'b1);
      idx     = '0;
      for (int i = 0; i < sdie_pkg::MASK_W; i++) begin
         if (low_bit[i]) begin
            idx = idx | sdie_pkg::CH_IDX_W'(i);
         end
      end

      work_step    = work_ff;
      out_kind_in  = out_kind_ff;
      out_ch_in    = out_ch_ff;
      out_value_in = out_value_ff;
      if (work_ff.time_pend) begin
         rest                = work_ff.changed;
         work_step.time_pend = 1'b0;
         out_kind_in         = sdie_pkg::KIND_TIME;
         out_ch_in           = '0;
         out_value_in        = work_ff.delta;
      end else begin
         rest              = work_ff.changed & ~low_bit;
         work_step.changed = rest;
         out_kind_in       = sdie_pkg::KIND_AMP;
         out_ch_in         = idx;
         out_value_in      = work_ff.mask[idx]
                           ? {{(sdie_pkg::TIME_W-sdie_pkg::AMP10_W){1'b0}}, work_ff.amp10}
                           : '0;
      end
      last        = (rest == '0);
      out_last_in = last;

      // free for the next sample once the last transfer of this one leaves
      take = ~busy | (fire & last);

      if (load) begin
         work_in = work_new;
      end else if (fire) begin
         work_in = work_step;
      end else begin
         work_in = work_ff;
      end

      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.time_pend <= 1'b0;
         work_ff.changed   <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         work_ff.time_pend <= work_in.time_pend;
         work_ff.changed   <= work_in.changed;
         out_valid_ff      <= out_valid_in;
      end
      work_ff.delta <= work_in.delta;
      work_ff.mask  <= work_in.mask;
      work_ff.amp10 <= work_in.amp10;
      if (fire) begin
         out_kind_ff  <= out_kind_in;
         out_ch_ff    <= out_ch_in;
         out_value_ff <= out_value_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.instr_kind     = out_kind_ff;
   assign rsp_ch.channel_index  = out_ch_ff;
   assign rsp_ch.instr_value    = out_value_ff;
   assign rsp_ch.last_of_sample = out_last_ff;

endmodule

// ===== hw/rtl/sample_delta_instruction_encoder_unit.sv =====
`timescale 1ns / 1ps
// A sample's first instruction passes the work register, then the result register.
// Throughput: one instruction per cycle unless the output stalls; a sample yields
// 0 to 9 instructions; the next is taken as its last one issues, at once if none.
// Barring stalls, emit walks changed channels one per cycle into the result register.
// Reset (synchronous) clears previous time and mask to zero and drops pending work.
module sample_delta_instruction_encoder_unit #(
   parameter int CHANNELS = sdie_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sdie_req_if.sink    req_ch,
   sdie_rsp_if.source  rsp_ch
);

   sdie_pkg::work_type work;
   logic               take;
   logic               accept;

   assign req_ch.ready = take;
   assign accept       = req_ch.valid & take;

   sdie_delta #(
      .CHANNELS (CHANNELS)
   ) u_delta (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sample_time_ms (req_ch.sample_time_ms),
      .channel_mask   (req_ch.channel_mask),
      .amplitude_pct  (req_ch.amplitude_pct),
      .first_sample   (req_ch.first_sample),
      .work           (work)
   );

   sdie_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .work_new (work),
      .take     (take),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  TAIL_CYCLES  = 12;
   localparam int  RANDOM_ITEMS = 360;
   localparam int  IDLE_PCT     = 35;
   localparam int  MAX_REPORTS  = 10;
   localparam int  AMP_SCALE    = 10;

   typedef struct {
      logic [sdie_pkg::TIME_W-1:0] t;
      logic [sdie_pkg::MASK_W-1:0] mask;
      logic [sdie_pkg::AMP_W-1:0]  amp;
      logic                        first;
   } sample_type;

   typedef struct {
      logic                          kind;
      logic [sdie_pkg::CH_IDX_W-1:0] idx;
      logic [sdie_pkg::TIME_W-1:0]   value;
      logic                          last;
   } instr_type;

   logic clock;
   logic reset;

   sdie_req_if req_bus ();
   sdie_rsp_if rsp_bus ();

   sample_delta_instruction_encoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   sample_type                  sample_backlog[$];
   instr_type                   pending_instrs[$];
   sample_type                  in_flight;
   logic [sdie_pkg::TIME_W-1:0] last_time;
   logic [sdie_pkg::MASK_W-1:0] last_mask;
   int                          samples_sent;
   int                          mismatches;
   logic                        burst;

   // no idling on either side while this window of samples goes through
   assign burst = (samples_sent >= 150) && (samples_sent < 230);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // expected instructions for one sample, appended in emit order
   function automatic void encode_sample(input sample_type s);
      logic [sdie_pkg::TIME_W-1:0] delta;
      logic [sdie_pkg::MASK_W-1:0] changed;
      logic [sdie_pkg::TIME_W-1:0] val;
      instr_type                   item;
      int                          n;
      int                          k;
      if (s.first) begin
         last_time = '0;
         last_mask = '0;
      end
      delta   = s.t - last_time;
      changed = last_mask ^ s.mask;
      n = $countones(changed) + ((delta != '0) ? 1 : 0);
      k = 0;
      if (delta != '0) begin
         k++;
         item = '{sdie_pkg::KIND_TIME, '0, delta, (k == n)};
         pending_instrs = {pending_instrs, item};
      end
      for (int i = 0; i < sdie_pkg::MASK_W; i++) begin
         if (changed[i]) begin
            k++;
            val = s.mask[i] ? sdie_pkg::TIME_W'(s.amp) * sdie_pkg::TIME_W'(AMP_SCALE) : '0;
            item = '{sdie_pkg::KIND_AMP, sdie_pkg::CH_IDX_W'(i), val, (k == n)};
            pending_instrs = {pending_instrs, item};
         end
      end
      last_time = s.t;
      last_mask = s.mask;
   endfunction

   task automatic add_sample(input logic [sdie_pkg::TIME_W-1:0] t,
                             input logic [sdie_pkg::MASK_W-1:0] mask,
                             input logic [sdie_pkg::AMP_W-1:0] amp, input logic first);
      sample_type s;
      s = '{t, mask, amp, first};
      sample_backlog = {sample_backlog, s};
   endtask

   // driver: holds each sample until its transfer, then predicts it
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            encode_sample(in_flight);
            samples_sent++;
         end
         if (sample_backlog.size() != 0 && (burst || $urandom_range(0, 99) >= IDLE_PCT)) begin
            in_flight = sample_backlog.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.sample_time_ms <= in_flight.t;
            req_bus.channel_mask   <= in_flight.mask;
            req_bus.amplitude_pct  <= in_flight.amp;
            req_bus.first_sample   <= in_flight.first;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, compares each transfer with the oldest expectation
   always @(posedge clock) begin
      instr_type exp_i;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= burst || ($urandom_range(0, 99) >= IDLE_PCT);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_instrs.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected instruction: kind %0d ch %0d value %0d last %0d",
                           rsp_bus.instr_kind, rsp_bus.channel_index,
                           rsp_bus.instr_value, rsp_bus.last_of_sample);
            end else begin
               exp_i = pending_instrs.pop_front();
               if (rsp_bus.instr_kind !== exp_i.kind || rsp_bus.channel_index !== exp_i.idx ||
                   rsp_bus.instr_value !== exp_i.value ||
                   rsp_bus.last_of_sample !== exp_i.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     // kind/ch/value/last
                     $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              exp_i.kind, exp_i.idx, exp_i.value, exp_i.last,
                              rsp_bus.instr_kind, rsp_bus.channel_index,
                              rsp_bus.instr_value, rsp_bus.last_of_sample);
               end
            end
         end
      end
   end

   initial begin
      logic [sdie_pkg::TIME_W-1:0] gen_time;
      logic [sdie_pkg::MASK_W-1:0] gen_mask;
      logic [sdie_pkg::TIME_W-1:0] t;
      logic [sdie_pkg::MASK_W-1:0] m;
      logic                        f;
      int                          r;
      int                          cycle_count;
      logic                        timed_out;

      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.sample_time_ms = '0;
      req_bus.channel_mask   = '0;
      req_bus.amplitude_pct  = '0;
      req_bus.first_sample   = 1'b0;
      rsp_bus.ready          = 1'b0;
      last_time    = '0;
      last_mask    = '0;
      samples_sent = 0;
      mismatches   = 0;
      cycle_count  = 0;
      timed_out    = 1'b0;

      // directed: silent samples, amplitude-only change, wrap, full masks
      add_sample(32'd0, 8'h00, 8'd0, 1'b1);
      add_sample(32'd100, 8'h01, 8'd50, 1'b0);
      add_sample(32'd100, 8'h01, 8'd77, 1'b0);
      add_sample(32'd100, 8'hFF, 8'd255, 1'b0);
      add_sample(32'hFFFF_FFFF, 8'h00, 8'd255, 1'b0);
      add_sample(32'd5, 8'hFF, 8'd100, 1'b0);
      add_sample(32'd3, 8'hAA, 8'd101, 1'b0);
      add_sample(32'd3, 8'hAA, 8'd0, 1'b0);
      add_sample(32'd0, 8'h00, 8'd0, 1'b1);
      add_sample(32'hFFFF_FFFF, 8'hFF, 8'd255, 1'b1);
      add_sample(32'hFFFF_FFFF, 8'h55, 8'd0, 1'b0);
      add_sample(32'd7, 8'h80, 8'd1, 1'b1);
      add_sample(32'd8, 8'h80, 8'd200, 1'b0);
      add_sample(32'h8000_0000, 8'h7F, 8'd128, 1'b0);
      add_sample(32'h0000_0000, 8'h80, 8'd254, 1'b0);
      add_sample(32'h5555_5555, 8'h00, 8'd10, 1'b1);
      add_sample(32'hAAAA_AAAA, 8'hFF, 8'd170, 1'b0);
      add_sample(32'hAAAA_AAAA, 8'hFF, 8'd85, 1'b1);

      gen_time = 32'hAAAA_AAAA;
      gen_mask = 8'hFF;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         f = 1'b0;
         t = gen_time;
         m = gen_mask;
         if (r < 5) begin
            f = 1'b1;
            t = ($urandom_range(0, 3) == 0) ? $urandom()
                                            : sdie_pkg::TIME_W'($urandom_range(0, 20));
            m = ($urandom_range(0, 3) == 0) ? 8'h00 : sdie_pkg::MASK_W'($urandom());
         end else if (r < 10) begin
            // repeat of the previous sample: no instruction at all
         end else if (r < 16) begin
            t = $urandom();
            m = sdie_pkg::MASK_W'($urandom());
         end else begin
            t = gen_time + sdie_pkg::TIME_W'($urandom_range(0, 60));
            case ($urandom_range(0, 3))
               0: m = gen_mask ^ (sdie_pkg::MASK_W'(1) << $urandom_range(0, sdie_pkg::MASK_W - 1));
               1: m = gen_mask ^ (sdie_pkg::MASK_W'($urandom()) & sdie_pkg::MASK_W'($urandom()));
               2: m = gen_mask;
               default: m = sdie_pkg::MASK_W'($urandom());
            endcase
         end
         add_sample(t, m, sdie_pkg::AMP_W'($urandom()), f);
         gen_time = t;
         gen_mask = m;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out && !(sample_backlog.size() == 0 && !req_bus.valid &&
                             pending_instrs.size() == 0)) begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT)
            timed_out = 1'b1;
      end
      if (!timed_out)
         repeat (TAIL_CYCLES) @(negedge clock);

      if (timed_out) begin
         $display("CHECK FAILED");
      end else if (mismatches == 0 && pending_instrs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
